// ----- hdl/avsm_pkg.sv -----
// ----------------------------------------------------------------------------
// avsm_pkg
// Shared constants and types for the skip mode reference selection block.
// ----------------------------------------------------------------------------
package avsm_pkg;

    localparam int NUM_REFS   = 7;
    localparam int HINT_WIDTH = 8;

    // signed wrapped distance, one bit wider than a hint
    localparam int DIST_W   = HINT_WIDTH + 1;
    localparam int IDX_W    = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;
    localparam int FRAME_W  = 3;
    localparam int BITS_W   = 4;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER_HINT_ENABLE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER_HINT_BITS   = 1'd1;
    localparam logic [BITS_W-1:0]     ORDER_HINT_BITS_RST   = 4'd7;

    // input tdata layout
    localparam int IN_INTRA_LSB   = 0;
    localparam int IN_REFSEL_LSB  = 1;
    localparam int IN_CUR_LSB     = 2;
    localparam int IN_REF0_LSB    = IN_CUR_LSB + HINT_WIDTH;
    localparam int IN_PRESENT_LSB = IN_REF0_LSB + 7 * HINT_WIDTH;
    localparam int S_TDATA_W      = ((IN_PRESENT_LSB + 1 + 7) / 8) * 8;

    // output tdata layout
    localparam int M_TDATA_W = 8;

    typedef logic [HINT_WIDTH-1:0]    hint_t;
    typedef logic signed [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [FRAME_W-1:0]       frame_t;
    typedef logic [BITS_W-1:0]        bits_t;

    typedef struct packed {
        logic en2;
        logic en3;
    } pipe_ctl_t;

    typedef struct packed {
        logic   allowed;
        frame_t first;
        frame_t second;
        logic   present;
    } result_t;

endpackage

// ----- hdl/avsm_lane.sv -----
// ----------------------------------------------------------------------------
// avsm_lane
// One reference slot: wrapped signed distance of its hint from the current
// hint, modulo 2^bits, registered.
// ----------------------------------------------------------------------------
module avsm_lane (
    input  logic                 aclk,
    input  logic                 en,
    input  avsm_pkg::hint_t      hint,
    input  avsm_pkg::hint_t      cur,
    input  avsm_pkg::bits_t      bits,
    output avsm_pkg::dist_t      dist_reg
);

    avsm_pkg::hint_t diff;
    avsm_pkg::hint_t mask;
    logic            sign;
    avsm_pkg::dist_t dist_next;

    always_comb begin
        diff = cur;
        diff = hint - cur;
        for (int k = 0; k < avsm_pkg::HINT_WIDTH; k++) begin
            mask[k] = (k < int'(bits));
        end
        sign = diff[3'(bits - 4'd1)];
        // sign extend from the top used bit
        dist_next = {sign, (diff & mask) | (sign ? ~mask : '0)};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
        end
    end

endmodule

// ----- hdl/avsm_merge.sv -----
// ----------------------------------------------------------------------------
// avsm_merge
// Combines the lane distances: nearest forward and backward slot, then the
// second forward slot when no backward one exists, and the final result.
// ----------------------------------------------------------------------------
module avsm_merge (
    input  logic                 aclk,
    input  avsm_pkg::pipe_ctl_t  ctl,
    input  avsm_pkg::bits_t      bits,
    input  avsm_pkg::dist_t      lane_dist [avsm_pkg::NUM_REFS],
    input  logic                 cand,
    input  logic                 present,
    output avsm_pkg::result_t    result_reg
);

    // stage 2: nearest forward / backward
    logic            fwd_found_next, bwd_found_next;
    avsm_pkg::idx_t  fwd_idx_next, bwd_idx_next;
    avsm_pkg::dist_t fwd_d_next, bwd_d_next;

    logic            fwd_found_reg, bwd_found_reg;
    avsm_pkg::idx_t  fwd_idx_reg, bwd_idx_reg;
    avsm_pkg::dist_t fwd_d_reg;
    avsm_pkg::dist_t dist2_reg [avsm_pkg::NUM_REFS];
    logic            cand2_reg, present2_reg;

    always_comb begin
        fwd_found_next = 1'b0;
        bwd_found_next = 1'b0;
        fwd_idx_next   = '0;
        bwd_idx_next   = '0;
        fwd_d_next     = '0;
        bwd_d_next     = '0;
        for (int i = 0; i < avsm_pkg::NUM_REFS; i++) begin
            if (lane_dist[i] < 0) begin
                if (!fwd_found_next || lane_dist[i] > fwd_d_next) begin
                    fwd_found_next = 1'b1;
                    fwd_idx_next   = avsm_pkg::IDX_W'(i);
                    fwd_d_next     = lane_dist[i];
                end
            end else if (lane_dist[i] > 0) begin
                if (!bwd_found_next || lane_dist[i] < bwd_d_next) begin
                    bwd_found_next = 1'b1;
                    bwd_idx_next   = avsm_pkg::IDX_W'(i);
                    bwd_d_next     = lane_dist[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en2) begin
            fwd_found_reg <= fwd_found_next;
            bwd_found_reg <= bwd_found_next;
            fwd_idx_reg   <= fwd_idx_next;
            bwd_idx_reg   <= bwd_idx_next;
            fwd_d_reg     <= fwd_d_next;
            dist2_reg     <= lane_dist;
            cand2_reg     <= cand;
            present2_reg  <= present;
        end
    end

    // stage 3: second forward slot and ordering
    logic                        sec_found;
    avsm_pkg::idx_t              sec_idx;
    avsm_pkg::dist_t             sec_d;
    logic [avsm_pkg::DIST_W-1:0] half;
    logic                        fwd_at_half;
    logic                        oth_found;
    avsm_pkg::idx_t              oth_idx;
    logic                        allowed;
    avsm_pkg::idx_t              lo_idx, hi_idx;
    avsm_pkg::result_t           result_next;

    always_comb begin
        sec_found   = 1'b0;
        sec_idx     = '0;
        sec_d       = '0;
        half        = avsm_pkg::DIST_W'(1) << (bits - 4'd1);
        // forward pick half the hint space away: a slot on the current
        // frame wraps to behind it
        fwd_at_half = ($unsigned(fwd_d_reg) + half) == '0;
        for (int i = 0; i < avsm_pkg::NUM_REFS; i++) begin
            if (dist2_reg[i] < fwd_d_reg || (fwd_at_half && dist2_reg[i] == '0)) begin
                if (!sec_found || dist2_reg[i] > sec_d) begin
                    sec_found = 1'b1;
                    sec_idx   = avsm_pkg::IDX_W'(i);
                    sec_d     = dist2_reg[i];
                end
            end
        end
        oth_found = bwd_found_reg ? 1'b1 : sec_found;
        oth_idx   = bwd_found_reg ? bwd_idx_reg : sec_idx;
        allowed   = cand2_reg && fwd_found_reg && oth_found;
        lo_idx    = (fwd_idx_reg < oth_idx) ? fwd_idx_reg : oth_idx;
        hi_idx    = (fwd_idx_reg < oth_idx) ? oth_idx : fwd_idx_reg;

        result_next.allowed = allowed;
        result_next.first   = allowed ? avsm_pkg::FRAME_W'(lo_idx) + 3'd1 : '0;
        result_next.second  = allowed ? avsm_pkg::FRAME_W'(hi_idx) + 3'd1 : '0;
        result_next.present = allowed && present2_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en3) begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- hdl/av1_skip_mode_frame_select_core.sv -----
// ----------------------------------------------------------------------------
// av1_skip_mode_frame_select_core
// Skip mode reference selection for one frame header per transaction.
//
//   channel   dir   width  contents
//   s_axis    in    72     intra, refsel, cur hint, 7 ref hints, present bit
//   m_axis    out   8      allowed, first frame, second frame, present
//   cfg       in    1+4    order_hint_enable, order_hint_bits
//
// Three register stages: lane distances, nearest forward/backward merge,
// second forward search and output. One transaction per cycle sustained
// while m_tready is high. Each stage has its own valid bit, so a stalled
// output only blocks the input once all stages are full. aresetn is
// synchronous and clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module av1_skip_mode_frame_select_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    // cfg_wdata: register value
    input  logic                              cfg_wr_en,
    input  logic [avsm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [avsm_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: frame_is_intra, ref select, current_hint,
    //          ref_hint_0 .. ref_hint_6, present_bit, zero pad
    input  logic [avsm_pkg::S_TDATA_W-1:0]    s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: skip_mode_allowed, skip_frame_first, skip_frame_second,
    //          skip_present
    output logic [avsm_pkg::M_TDATA_W-1:0]    m_tdata
);

    // configuration
    logic            ohe_reg;
    avsm_pkg::bits_t bits_reg;
    avsm_pkg::bits_t bits_wr;

    always_comb begin
        // clamp to 1..HINT_WIDTH on write
        if (cfg_wdata == '0) begin
            bits_wr = 4'd1;
        end else if (cfg_wdata > avsm_pkg::BITS_W'(avsm_pkg::HINT_WIDTH)) begin
            bits_wr = avsm_pkg::BITS_W'(avsm_pkg::HINT_WIDTH);
        end else begin
            bits_wr = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ohe_reg  <= 1'b0;
            bits_reg <= avsm_pkg::ORDER_HINT_BITS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                avsm_pkg::REG_ORDER_HINT_ENABLE: ohe_reg  <= cfg_wdata[0];
                avsm_pkg::REG_ORDER_HINT_BITS:   bits_reg <= bits_wr;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic                v1_reg, v2_reg, v3_reg;
    logic                en1;
    avsm_pkg::pipe_ctl_t ctl;

    always_comb begin
        ctl.en3  = !v3_reg || m_tready;
        ctl.en2  = !v2_reg || ctl.en3;
        en1      = !v1_reg || ctl.en2;
        s_tready = en1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1)     v1_reg <= s_tvalid;
            if (ctl.en2) v2_reg <= v1_reg;
            if (ctl.en3) v3_reg <= v2_reg;
        end
    end

    // stage 1 sideband
    logic cand1_reg, present1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            cand1_reg    <= !s_tdata[avsm_pkg::IN_INTRA_LSB] &&
                            s_tdata[avsm_pkg::IN_REFSEL_LSB] && ohe_reg;
            present1_reg <= s_tdata[avsm_pkg::IN_PRESENT_LSB];
        end
    end

    // distance lanes
    avsm_pkg::dist_t lane_dist [avsm_pkg::NUM_REFS];

    for (genvar i = 0; i < avsm_pkg::NUM_REFS; i++) begin : g_lane
        avsm_lane u_lane (
            .aclk     (aclk),
            .en       (en1),
            .hint     (s_tdata[avsm_pkg::IN_REF0_LSB + i * avsm_pkg::HINT_WIDTH
                               +: avsm_pkg::HINT_WIDTH]),
            .cur      (s_tdata[avsm_pkg::IN_CUR_LSB +: avsm_pkg::HINT_WIDTH]),
            .bits     (bits_reg),
            .dist_reg (lane_dist[i])
        );
    end

    avsm_pkg::result_t result;

    avsm_merge u_merge (
        .aclk       (aclk),
        .ctl        (ctl),
        .bits       (bits_reg),
        .lane_dist  (lane_dist),
        .cand       (cand1_reg),
        .present    (present1_reg),
        .result_reg (result)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {result.present, result.second, result.first, result.allowed};

endmodule
